FILE: sv/vmc_pkg.sv
`timescale 1ns / 1ps
package vmc_pkg;

    localparam int KEY_SLOTS = 24;

    typedef enum logic {
        OP_BYTE  = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CFG_KEY_LOW  = 2'd0,
        CFG_KEY_HIGH = 2'd1,
        CFG_KEY_LEN  = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_CHAR   = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_DIGIT = 2'd1,
        BK_FLUSH = 2'd2,
        BK_EMIT  = 2'd3
    } bk_state_t;

    localparam logic [31:0] CMD_L = 32'h2121214C;
    localparam logic [31:0] CMD_S = 32'h21212153;
    localparam logic [13:0] PERIOD_RESET = 14'd1000;
    localparam logic [13:0] PERIOD_FLUSH = 14'd200;
    localparam logic [15:0] PERIOD_RESET_BCD = 16'h1000;
    localparam logic [15:0] PERIOD_FLUSH_BCD = 16'h0200;

    // classified work passed from front to back
    typedef struct packed {
        logic        flush;
        logic        put_char;
        logic [7:0]  char_val;
        logic        put_digits;
        logic        set_period;
        logic [13:0] period_val;
        logic [15:0] period_bcd;
    } vmc_cmd_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // (a + b) mod 26 for a, b below 26
    function automatic logic [4:0] add26(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 6'd26) ? 5'(s - 6'd26) : s[4:0];
    endfunction

    function automatic logic [4:0] mod26(input logic [4:0] v);
        return (v >= 5'd26) ? 5'(v - 5'd26) : v;
    endfunction

endpackage

FILE: sv/vmc_if.sv
`timescale 1ns / 1ps
interface vmc_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;
    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface vmc_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  text_byte;
    logic        last;
    logic [13:0] blink_period;
    modport source (output valid, output kind, output text_byte, output last,
                    output blink_period, input ready);
    modport sink   (input valid, input kind, input text_byte, input last,
                    input blink_period, output ready);
endinterface

interface vmc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [59:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/vmc_keytab.sv
`timescale 1ns / 1ps
module vmc_keytab (
    input  logic                    clk,
    input  logic                    rst_n,
    vmc_cfg_if.sink                 cfg,
    input  logic [4:0]              enc_pos,
    input  logic [4:0]              dec_pos,
    output logic [4:0]              enc_letter,
    output logic [4:0]              dec_letter,
    output logic [4:0]              key_len
);
    import vmc_pkg::*;

    logic [59:0] key_low_reg;
    logic [59:0] key_high_reg;
    logic [4:0]  key_length_reg;

    assign cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_length_reg <= 5'd1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_KEY_LOW:  key_low_reg    <= cfg.data;
                CFG_KEY_HIGH: key_high_reg   <= cfg.data;
                CFG_KEY_LEN:  key_length_reg <= cfg.data[4:0];
                default:      ;
            endcase
        end
    end

    function automatic logic [4:0] pick(input logic [4:0] p, input logic [59:0] lo,
                                        input logic [59:0] hi);
        logic [119:0] all;
        all = {hi, lo};
        return mod26(all[p*5 +: 5]);
    endfunction

    assign enc_letter = pick(enc_pos, key_low_reg, key_high_reg);
    assign dec_letter = pick(dec_pos, key_low_reg, key_high_reg);

    // clamp to 1..24
    always_comb
    begin
        if (key_length_reg == 5'd0)
            key_len = 5'd1;
        else if (key_length_reg > 5'(KEY_SLOTS))
            key_len = 5'(KEY_SLOTS);
        else
            key_len = key_length_reg;
    end
endmodule

FILE: sv/vmc_front.sv
`timescale 1ns / 1ps
module vmc_front (
    input  logic               clk,
    input  logic               rst_n,
    vmc_in_if.sink             in,
    input  logic               q_full,
    output logic               q_push,
    output vmc_pkg::vmc_cmd_t  q_data
);
    import vmc_pkg::*;

    logic [31:0] short_reg, short_next;
    logic [63:0] long_reg, long_next;
    logic [7:0]  up;
    logic        cmd_s_new;
    logic [13:0] val;

    assign in.ready = !q_full;
    assign q_push   = in.valid && !q_full;

    always_comb
    begin
        short_next = {short_reg[23:0], in.rx_byte};
        long_next  = {long_reg[55:0], in.rx_byte};
        up = (in.rx_byte >= 8'h61 && in.rx_byte <= 8'h7A) ? in.rx_byte - 8'h20 : in.rx_byte;
        cmd_s_new = (long_next[31:0] == CMD_S);
        val = 14'(long_next[27:24]) * 14'd1000 + 14'(long_next[19:16]) * 14'd100
            + 14'(long_next[11:8]) * 14'd10 + 14'(long_next[3:0]);

        q_data = '0;
        q_data.flush      = (in.operation == OP_FLUSH);
        q_data.char_val   = up;
        q_data.period_val = val;
        q_data.period_bcd = {long_next[27:24], long_next[19:16],
                             long_next[11:8], long_next[3:0]};
        if (in.operation == OP_BYTE)
        begin
            q_data.put_digits = (short_next == CMD_L);
            q_data.put_char   = (short_next != CMD_L) && !cmd_s_new
                              && up >= 8'h41 && up <= 8'h5A;
            q_data.set_period = (long_next[63:32] == CMD_S)
                && is_digit(long_next[31:24]) && is_digit(long_next[23:16])
                && is_digit(long_next[15:8]) && is_digit(long_next[7:0])
                && (val != 14'd0);
        end
        if (short_next == CMD_L)
            short_next = '0;
        if (long_next[63:32] == CMD_S)
            long_next = '0;
    end

    // match windows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg <= '0;
            long_reg  <= '0;
        end
        else if (q_push && in.operation == OP_BYTE)
        begin
            short_reg <= short_next;
            long_reg  <= long_next;
        end
    end
endmodule

FILE: sv/vmc_queue.sv
`timescale 1ns / 1ps
module vmc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vmc_pkg::vmc_cmd_t  push_data,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output vmc_pkg::vmc_cmd_t  head
);
    import vmc_pkg::*;

    vmc_cmd_t   slot_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_data;
    end

    // two-entry pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

FILE: sv/vmc_back.sv
`timescale 1ns / 1ps
module vmc_back #(
    parameter int STORE_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  vmc_pkg::vmc_cmd_t  q_head,
    output logic               q_pop,
    input  logic [4:0]         enc_letter,
    input  logic [4:0]         dec_letter,
    input  logic [4:0]         key_len,
    output logic [4:0]         enc_pos,
    output logic [4:0]         dec_pos,
    vmc_out_if.source          out
);
    import vmc_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    logic [7:0]    store_mem [STORE_DEPTH];
    logic [7:0]    rd_data_reg;
    bk_state_t     state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [4:0]    kpos_reg, kpos_next;
    logic [4:0]    dpos_reg, dpos_next;
    logic [13:0]   period_reg, period_next;
    logic [15:0]   bcd_reg, bcd_next;
    logic [1:0]    dig_reg, dig_next;
    logic [3:0]    d_thou, d_hund, d_ten, d_one;
    logic          ov_reg, ov_next;
    logic          okind_reg, okind_next;
    logic [7:0]    obyte_reg, obyte_next;
    logic          olast_reg, olast_next;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_val;
    logic          rd_en;
    logic [4:0]    plain;
    logic          slot_free;

    assign enc_pos = kpos_reg;
    assign dec_pos = dpos_reg;
    assign slot_free = !ov_reg || out.ready;

    // period digits held alongside the binary period
    assign d_thou = bcd_reg[15:12];
    assign d_hund = bcd_reg[11:8];
    assign d_ten  = bcd_reg[7:4];
    assign d_one  = bcd_reg[3:0];

    // store memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_val;
        if (rd_en)
            rd_data_reg <= store_mem[idx_reg[AW-1:0]];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    if (q_head.put_digits)
                        state_next = BK_DIGIT;
                    else if (q_head.flush && count_reg != '0)
                        state_next = BK_FLUSH;
                end
            end
            BK_DIGIT:
            begin
                if (dig_reg == 2'd3 && slot_free)
                    state_next = BK_IDLE;
            end
            BK_FLUSH:  state_next = BK_EMIT;
            BK_EMIT:
            begin
                if (slot_free)
                    state_next = (idx_reg == count_reg) ? BK_IDLE : BK_FLUSH;
            end
            default:   state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        kpos_next   = kpos_reg;
        dpos_next   = dpos_reg;
        period_next = period_reg;
        bcd_next    = bcd_reg;
        dig_next    = dig_reg;
        ov_next     = ov_reg && !out.ready;
        okind_next  = okind_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_val  = '0;
        rd_en   = 1'b0;
        q_pop   = 1'b0;
        plain   = add26(5'(rd_data_reg - 8'h41), mod26(5'd26 - dec_letter));
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    if (q_head.flush)
                    begin
                        period_next = PERIOD_FLUSH;
                        bcd_next    = PERIOD_FLUSH_BCD;
                        kpos_next   = '0;
                        dpos_next   = '0;
                        idx_next    = '0;
                        if (count_reg == '0)
                        begin
                            q_pop = 1'b1;
                            ov_next = 1'b1;
                            okind_next = KIND_STATUS;
                            obyte_next = '0;
                            olast_next = 1'b1;
                        end
                        else
                            rd_en = 1'b1;
                    end
                    else if (q_head.put_digits)
                        dig_next = '0;
                    else
                    begin
                        q_pop = 1'b1;
                        if (q_head.put_char && count_reg < CW'(STORE_DEPTH))
                        begin
                            wr_en  = 1'b1;
                            wr_val = 8'(add26(5'(q_head.char_val - 8'h41), enc_letter))
                                   + 8'h41;
                            count_next = count_reg + 1'b1;
                            kpos_next = (kpos_reg + 5'd1 >= key_len) ? '0 : kpos_reg + 5'd1;
                        end
                        if (q_head.set_period)
                        begin
                            period_next = q_head.period_val;
                            bcd_next    = q_head.period_bcd;
                        end
                        ov_next = 1'b1;
                        okind_next = KIND_STATUS;
                        obyte_next = '0;
                        olast_next = 1'b1;
                    end
                end
            end
            BK_DIGIT:
            begin
                // one digit a cycle while the output slot is free, leading zeros skipped
                if (slot_free)
                begin
                    dig_next = dig_reg + 2'd1;
                    if (count_reg < CW'(STORE_DEPTH))
                    begin
                        priority case (dig_reg)
                            2'd0: wr_en = (d_thou != 0);
                            2'd1: wr_en = (d_thou != 0) || (d_hund != 0);
                            2'd2: wr_en = (d_thou != 0) || (d_hund != 0) || (d_ten != 0);
                            default: wr_en = 1'b1;
                        endcase
                        priority case (dig_reg)
                            2'd0: wr_val = 8'h30 + 8'(d_thou);
                            2'd1: wr_val = 8'h30 + 8'(d_hund);
                            2'd2: wr_val = 8'h30 + 8'(d_ten);
                            default: wr_val = 8'h30 + 8'(d_one);
                        endcase
                        if (wr_en)
                            count_next = count_reg + 1'b1;
                    end
                    if (dig_reg == 2'd3)
                    begin
                        q_pop = 1'b1;
                        ov_next = 1'b1;
                        okind_next = KIND_STATUS;
                        obyte_next = '0;
                        olast_next = 1'b1;
                    end
                end
            end
            BK_FLUSH:
            begin
                idx_next = idx_reg + 1'b1;
            end
            BK_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    okind_next = KIND_CHAR;
                    olast_next = (idx_reg == count_reg);
                    if (is_digit(rd_data_reg))
                        obyte_next = rd_data_reg;
                    else
                    begin
                        obyte_next = 8'(plain) + 8'h41;
                        dpos_next = (dpos_reg + 5'd1 >= key_len) ? '0 : dpos_reg + 5'd1;
                    end
                    if (idx_reg == count_reg)
                    begin
                        // read index back to the oldest entry for the next flush
                        q_pop = 1'b1;
                        count_next = '0;
                        idx_next = '0;
                    end
                    else
                        rd_en = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            kpos_reg   <= '0;
            dpos_reg   <= '0;
            period_reg <= PERIOD_RESET;
            bcd_reg    <= PERIOD_RESET_BCD;
            dig_reg    <= '0;
            ov_reg     <= 1'b0;
            okind_reg  <= 1'b0;
            obyte_reg  <= '0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            kpos_reg   <= kpos_next;
            dpos_reg   <= dpos_next;
            period_reg <= period_next;
            bcd_reg    <= bcd_next;
            dig_reg    <= dig_next;
            ov_reg     <= ov_next;
            okind_reg  <= okind_next;
            obyte_reg  <= obyte_next;
            olast_reg  <= olast_next;
        end
    end

    assign out.valid        = ov_reg;
    assign out.kind         = okind_reg;
    assign out.text_byte    = obyte_reg;
    assign out.last         = olast_reg;
    assign out.blink_period = period_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STORE_DEPTH)) else $error("store count overrun");
    a_kpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        kpos_reg < 5'(KEY_SLOTS)) else $error("key position out of range");
    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EMIT && slot_free && idx_reg == count_reg)
        |=> count_reg == '0) else $error("store not emptied after flush");
    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        period_reg != '0) else $error("zero blink period");
`endif
endmodule

FILE: sv/vigenere_message_cipher_stream_core.sv
`timescale 1ns / 1ps
// channel  | dir | fields
// in_ch    | in  | operation, rx_byte
// out_ch   | out | kind, text_byte, last, blink_period
// cfg_ch   | in  | index, data (key low, key high, key length)
//
// a received byte is handled in the back end's idle state; the L of !!!L enters the digit
// state, which steps through the period digits from thousands to ones, writing all but leading zeros
// a flush starts with the first read, then each stored character passes through read, then emit
// reset clears windows, count, key position; period returns to 1000
// a two-entry queue parts front and back so either side can stall alone
module vigenere_message_cipher_stream_core #(
    parameter int STORE_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    vmc_in_if.sink     in_ch,
    vmc_out_if.source  out_ch,
    vmc_cfg_if.sink    cfg_ch
);
    import vmc_pkg::*;

    logic       q_full, q_push, q_pop, q_ne;
    vmc_cmd_t   q_in, q_head;
    logic [4:0] enc_pos, dec_pos, enc_letter, dec_letter, key_len;

    vmc_keytab u_keytab (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_ch),
        .enc_pos(enc_pos), .dec_pos(dec_pos),
        .enc_letter(enc_letter), .dec_letter(dec_letter), .key_len(key_len)
    );

    vmc_front u_front (
        .clk(clk), .rst_n(rst_n), .in(in_ch),
        .q_full(q_full), .q_push(q_push), .q_data(q_in)
    );

    vmc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .head(q_head)
    );

    vmc_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_head(q_head), .q_pop(q_pop),
        .enc_letter(enc_letter), .dec_letter(dec_letter), .key_len(key_len),
        .enc_pos(enc_pos), .dec_pos(dec_pos), .out(out_ch)
    );
endmodule

FILE: sim/vmc_scoreboard.sv
`timescale 1ns / 1ps
module vmc_scoreboard #(
    parameter int STORE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        in_operation,
    input  logic [7:0]  in_rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        out_kind,
    input  logic [7:0]  out_text_byte,
    input  logic        out_last,
    input  logic [13:0] out_blink_period,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [59:0] cfg_data,
    output int          fail_count,
    output int          beats_due
);
    import vmc_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  text_byte;
        logic        last;
        logic [13:0] blink_period;
    } text_beat_t;

    // modelled block state
    logic [7:0]  cipher_mem [STORE_DEPTH];
    int          held_chars;
    int          key_pos;
    logic [31:0] win4;
    logic [63:0] win8;
    logic [13:0] period_ms;
    logic [59:0] key_lo;
    logic [59:0] key_hi;
    logic [4:0]  key_len;

    text_beat_t text_due [$];

    assign beats_due = text_due.size();

    function automatic int key_shift(input int pos);
        logic [4:0] v;
        if (pos < 12)
            v = key_lo[5*pos +: 5];
        else
            v = key_hi[5*(pos-12) +: 5];
        return int'(v) % 26;
    endfunction

    function automatic int next_key_pos(input int pos);
        int n;
        n = (key_len == 0) ? 1 : ((key_len > KEY_SLOTS) ? KEY_SLOTS : int'(key_len));
        return (pos + 1 >= n) ? 0 : pos + 1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic push_beat(input kind_t k, input logic [7:0] b, input logic l);
        text_beat_t t;
        t.kind = k;
        t.text_byte = b;
        t.last = l;
        t.blink_period = period_ms;
        text_due.push_back(t);
    endtask

    task automatic store_char(input logic [7:0] c);
        if (held_chars < STORE_DEPTH)
        begin
            cipher_mem[held_chars] = c;
            held_chars++;
        end
    endtask

    // flush: decipher and emit the whole store, or one status beat if it is empty
    task automatic predict_flush();
        int pos;
        int p;
        logic [7:0] s;
        pos = 0;
        period_ms = PERIOD_FLUSH;
        if (held_chars == 0)
            push_beat(KIND_STATUS, 8'h00, 1'b1);
        for (int i = 0; i < held_chars; i++)
        begin
            s = cipher_mem[i];
            if (s >= 8'h30 && s <= 8'h39)
                p = s;
            else
            begin
                p = ((int'(8'(s - 8'h41)) + 26 - key_shift(pos)) % 26) + 8'h41;
                pos = next_key_pos(pos);
            end
            push_beat(KIND_CHAR, 8'(p), i + 1 == held_chars);
        end
        held_chars = 0;
        key_pos = 0;
    endtask

    // received byte: windows, commands, encipher
    task automatic predict_byte(input logic [7:0] c);
        int u;
        int val;
        int div;
        int d;
        logic started;
        logic ok;
        logic [7:0] dc;
        win4 = {win4[23:0], c};
        win8 = {win8[55:0], c};
        if (win4 == CMD_L)
        begin
            started = 1'b0;
            div = 1000;
            while (div != 0)
            begin
                d = (int'(period_ms) / div) % 10;
                if (d != 0 || started || div == 1)
                begin
                    started = 1'b1;
                    store_char(8'(8'h30 + d));
                end
                div = div / 10;
            end
            win4 = '0;
        end
        else if (win8[31:0] != CMD_S)
        begin
            u = c;
            if (u >= 8'h61 && u <= 8'h7A)
                u = u - 8'h20;
            if (u >= 8'h41 && u <= 8'h5A && held_chars < STORE_DEPTH)
            begin
                store_char(8'(((u - 8'h41) + key_shift(key_pos)) % 26 + 8'h41));
                key_pos = next_key_pos(key_pos);
            end
        end
        if (win8[63:32] == CMD_S)
        begin
            val = 0;
            ok = 1'b1;
            for (int i = 0; i < 4; i++)
            begin
                dc = win8[24 - 8*i +: 8];
                if (!(dc >= 8'h30 && dc <= 8'h39))
                    ok = 1'b0;
                else
                    val = val * 10 + (dc - 8'h30);
            end
            if (ok && val > 0)
                period_ms = 14'(val);
            win8 = '0;
        end
        push_beat(KIND_STATUS, 8'h00, 1'b1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        text_beat_t want;
        if (!rst_n)
        begin
            held_chars = 0;
            key_pos    = 0;
            win4       = '0;
            win8       = '0;
            period_ms  = PERIOD_RESET;
            key_lo     = '0;
            key_hi     = '0;
            key_len    = 5'd1;
            fail_count = 0;
            text_due.delete();
        end
        else
        begin
            // compare an output beat with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (text_due.size() == 0)
                    report_mismatch("output beat with nothing predicted");
                else
                begin
                    want = text_due.pop_front();
                    if (out_kind !== want.kind)
                        report_mismatch($sformatf("kind %0b want %0b", out_kind, want.kind));
                    if (out_text_byte !== want.text_byte)
                        report_mismatch($sformatf("text_byte %02h want %02h",
                                                  out_text_byte, want.text_byte));
                    if (out_last !== want.last)
                        report_mismatch($sformatf("last %0b want %0b", out_last, want.last));
                    if (out_blink_period !== want.blink_period)
                        report_mismatch($sformatf("blink_period %0d want %0d",
                                                  out_blink_period, want.blink_period));
                end
            end
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_KEY_LOW:  key_lo  = cfg_data;
                    CFG_KEY_HIGH: key_hi  = cfg_data;
                    CFG_KEY_LEN:  key_len = cfg_data[4:0];
                    default: ;
                endcase
            end
            // input beats
            if (in_valid && in_ready)
            begin
                if (op_t'(in_operation) == OP_FLUSH)
                    predict_flush();
                else
                    predict_byte(in_rx_byte);
            end
        end
    end

endmodule

FILE: sim/tb_vigenere_message_cipher_stream_core.sv
`timescale 1ns / 1ps
module tb_vigenere_message_cipher_stream_core;
    import vmc_pkg::*;

    localparam int  ITEM_TARGET = 480;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   beats_due;
    int   items_sent;
    int   cycles;
    logic idling;
    int   stall_left;

    vmc_in_if  in_ch ();
    vmc_out_if out_ch ();
    vmc_cfg_if cfg_ch ();

    vigenere_message_cipher_stream_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    vmc_scoreboard u_scoreboard (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_ch.valid),
        .in_ready         (in_ch.ready),
        .in_operation     (in_ch.operation),
        .in_rx_byte       (in_ch.rx_byte),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .out_kind         (out_ch.kind),
        .out_text_byte    (out_ch.text_byte),
        .out_last         (out_ch.last),
        .out_blink_period (out_ch.blink_period),
        .cfg_valid        (cfg_ch.valid),
        .cfg_ready        (cfg_ch.ready),
        .cfg_index        (cfg_ch.index),
        .cfg_data         (cfg_ch.data),
        .fail_count       (fail_count),
        .beats_due        (beats_due)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // run limit
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 18) - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    task automatic send_beat(input op_t op, input logic [7:0] b);
        if (idling && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.rx_byte   <= b;
        @(negedge clk);
        while (!in_ch.ready) @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(OP_BYTE, s[i]);
    endtask

    // wait for all predicted beats, then let the back end drain
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (beats_due != 0) @(posedge clk);
        repeat (160) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [59:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        @(negedge clk);
        while (!cfg_ch.ready) @(negedge clk);
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [119:0] key_from_word(input string w);
        logic [119:0] k;
        k = '0;
        for (int i = 0; i < w.len() && i < KEY_SLOTS; i++)
            k[5*i +: 5] = 5'(w[i] - 8'h41);
        return k;
    endfunction

    task automatic random_key();
        logic [63:0] r;
        int len_pick;
        r = {$urandom, $urandom};
        write_reg(CFG_KEY_LOW, r[59:0]);
        r = {$urandom, $urandom};
        write_reg(CFG_KEY_HIGH, r[59:0]);
        len_pick = $urandom_range(0, 9);
        write_reg(CFG_KEY_LEN, len_pick == 0 ? 60'd24 :
                               len_pick == 1 ? 60'd1 : 60'($urandom_range(0, 31)));
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'(8'h41 + $urandom_range(0, 25));
        return $urandom_range(0, 1) ? (c | 8'h20) : c;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    // one random sequence, mostly well-formed
    task automatic random_sequence();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            n = $urandom_range(1, 12);
            repeat (n) send_beat(OP_BYTE, $urandom_range(0, 9) ? rand_letter() : rand_digit());
        end
        else if (pick < 55)
            send_text("!!!L");
        else if (pick < 68)
        begin
            send_text("!!!S");
            repeat (4) send_beat(OP_BYTE, $urandom_range(0, 7) ? rand_digit()
                                                               : 8'($urandom_range(0, 255)));
        end
        else if (pick < 78)
            send_beat(OP_FLUSH, 8'($urandom_range(0, 255)));
        else if (pick < 81)
            repeat (70) send_beat(OP_BYTE, rand_letter());
        else if (pick < 86)
            send_text("!!!");
        else
            send_beat(OP_BYTE, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        logic [119:0] k;
        rst_n           = 1'b0;
        idling          = 1'b1;
        stall_left      = 0;
        items_sent      = 0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_BYTE;
        in_ch.rx_byte   <= 8'h00;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_KEY_LOW;
        cfg_ch.data     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: fixed key word, commands and edge bytes
        k = key_from_word("BOLDFEARLESSCONFIDENT");
        write_reg(CFG_KEY_LOW, k[59:0]);
        write_reg(CFG_KEY_HIGH, k[119:60]);
        write_reg(CFG_KEY_LEN, 60'd21);
        send_beat(OP_FLUSH, 8'h00);
        send_text("Az");
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, 8'hFF);
        send_text("9!!!L");
        send_beat(OP_FLUSH, 8'hFF);
        send_text("!!!S0500!!!L");
        send_text("!!!S0000!!!SaB12");
        send_beat(OP_FLUSH, 8'h00);
        settle();

        // key letters above 25, key length zero and beyond range
        write_reg(CFG_KEY_LOW, '1);
        write_reg(CFG_KEY_HIGH, '1);
        write_reg(CFG_KEY_LEN, 60'd0);
        write_reg(CFG_SPARE, '1);
        send_text("Hi");
        send_beat(OP_FLUSH, 8'h00);
        settle();
        write_reg(CFG_KEY_LEN, 60'd31);
        settle();

        // random phases with fresh keys
        while (items_sent < ITEM_TARGET)
        begin
            random_key();
            n_phase: for (int j = 0; j < 25 && items_sent < ITEM_TARGET; j++)
            begin
                if (items_sent > ITEM_TARGET - 80)
                    idling = 1'b0;
                random_sequence();
            end
            send_beat(OP_FLUSH, 8'h00);
            settle();
        end

        settle();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/vmc_pkg.sv
sv/vmc_if.sv
sv/vmc_keytab.sv
sv/vmc_front.sv
sv/vmc_queue.sv
sv/vmc_back.sv
sv/vigenere_message_cipher_stream_core.sv
sim/vmc_scoreboard.sv
sim/tb_vigenere_message_cipher_stream_core.sv
